// File: src/boolean_expression_evaluator_assert.svh
// Assertion macros for the boolean expression evaluator.
`ifndef BOOLEAN_EXPRESSION_EVALUATOR_ASSERT_SVH
`define BOOLEAN_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge out of reset.
`define BEE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every edge, reset included.
`define BEE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BEE_ASSERT(lbl, prop, msg)
`define BEE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/bee_pkg.sv
// Types and constants shared by the boolean expression evaluator modules.
package bee_pkg;

   localparam int NEST_DEPTH = 16;
   localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);
   localparam int NUM_VARS   = 26;
   localparam int VAR_IDX_W  = $clog2(NUM_VARS);

   localparam logic [7:0] CHAR_NOT     = 8'h21;
   localparam logic [7:0] CHAR_AND     = 8'h2A;
   localparam logic [7:0] CHAR_OR      = 8'h2B;
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [2:0] CLS_START   = 3'd0;
   localparam logic [2:0] CLS_OPERAND = 3'd1;
   localparam logic [2:0] CLS_BINOP   = 3'd2;
   localparam logic [2:0] CLS_NOT     = 3'd3;
   localparam logic [2:0] CLS_OPEN    = 3'd4;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_ILLEGAL    = 3'd1;
   localparam logic [2:0] ERR_MISPLACED  = 3'd2;
   localparam logic [2:0] ERR_UNBALANCED = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd4;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd5;

   typedef struct packed {
      logic term_neg;
      logic term_and;
      logic term_or;
   } terms_type;

   localparam terms_type TERMS_RESET = '{term_neg: 1'b0, term_and: 1'b1, term_or: 1'b0};

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       expression_valid;
      logic       expression_value;
      logic [2:0] error_kind;
   } rsp_type;

endpackage

// File: src/bee_stack_cell.sv
// One entry of the shifting level stack.
module bee_stack_cell
   import bee_pkg::*;
(
   input  logic           clock,
   input  stack_ctrl_type ctrl,
   input  terms_type      from_above,
   input  terms_type      from_below,
   output terms_type      entry
);

   terms_type entry_ff;
   terms_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         entry_in = from_above;
      end else if (ctrl.pop) begin
         entry_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: src/bee_stack.sv
// Level stack built as a row of shifting cells; cell 0 is the top.
module bee_stack
   import bee_pkg::*;
(
   input  logic           clock,
   input  stack_ctrl_type ctrl,
   input  terms_type      push_data,
   output terms_type      top_data
);

   terms_type entries [NEST_DEPTH];

   for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
      terms_type above;
      terms_type below;

      if (i == 0) begin : g_first
         assign above = push_data;
      end else begin : g_mid_above
         assign above = entries[i-1];
      end

      if (i == NEST_DEPTH - 1) begin : g_last
         assign below = entries[i];
      end else begin : g_mid_below
         assign below = entries[i+1];
      end

      bee_stack_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .from_above (above),
         .from_below (below),
         .entry      (entries[i])
      );
   end

   assign top_data = entries[0];

endmodule

// File: src/boolean_expression_evaluator.sv
// Top level of the streaming boolean expression evaluator.
//
// Usage: characters of an infix expression (A-Z/a-z, ! * + and parentheses)
// enter one per transaction on the req_ channel; last_char marks the end.
// Variable values come from the 26-bit csr_ register; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Only the last character of an expression produces a rsp_ transaction
// carrying the valid flag, the value and the error kind. Throughput: one
// character per cycle, save that a last character waits while the output
// register is full; each character is settled in the cycle it is accepted,
// and open parentheses shift the level stack cells one position in that cycle.
// The result sits in an output register; while it waits for rsp_ready,
// characters that are not last are still accepted, a last character is
// held off until the register frees up (same cycle as rsp_ready).
// Reset clears the expression state, the output valid and the csr_ register;
// the result data register and the stack cells hold no meaning until loaded.
module boolean_expression_evaluator
   import bee_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_write_en,
   input  logic [NUM_VARS-1:0] csr_write_data
);

   `include "boolean_expression_evaluator_assert.svh"

   logic [NUM_VARS-1:0] values_ff;
   terms_type           terms_ff, terms_in;
   logic [LEVEL_W-1:0]  nest_ff, nest_in;
   logic [2:0]          prev_ff, prev_in;
   logic [2:0]          err_ff, err_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic [7:0]          upper;
   logic                is_letter;
   logic [VAR_IDX_W-1:0] var_idx;
   logic                want_op;
   logic                inner;
   logic [2:0]          err_final;
   stack_ctrl_type      stack_ctrl;
   terms_type           stack_top;

   function automatic terms_type take_operand(terms_type t, logic v);
      terms_type r;
      r = t;
      if (!(v ^ t.term_neg)) begin
         r.term_and = 1'b0;
      end
      r.term_neg = 1'b0;
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_data.last_char;

   assign upper = (req_data.char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) ?
                  req_data.char_code - CASE_OFFSET : req_data.char_code;
   assign is_letter = upper inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
   assign var_idx   = VAR_IDX_W'(upper - CHAR_UPPER_A);
   assign want_op   = (prev_ff != CLS_OPERAND);
   assign inner     = terms_ff.term_or | terms_ff.term_and;

   bee_stack u_stack (
      .clock     (clock),
      .ctrl      (stack_ctrl),
      .push_data (terms_ff),
      .top_data  (stack_top)
   );

   always_comb begin
      terms_in   = terms_ff;
      nest_in    = nest_ff;
      prev_in    = prev_ff;
      err_in     = err_ff;
      stack_ctrl = '0;
      if (err_ff == ERR_NONE) begin
         if (is_letter) begin
            if (!want_op) begin
               err_in = ERR_MISPLACED;
            end else begin
               terms_in = take_operand(terms_ff, values_ff[var_idx]);
               prev_in  = CLS_OPERAND;
            end
         end else begin
            case (upper)
               CHAR_NOT: begin
                  if (!want_op) begin
                     err_in = ERR_MISPLACED;
                  end else begin
                     terms_in.term_neg = !terms_ff.term_neg;
                     prev_in           = CLS_NOT;
                  end
               end
               CHAR_AND: begin
                  if (want_op) begin
                     err_in = ERR_MISPLACED;
                  end else begin
                     prev_in = CLS_BINOP;
                  end
               end
               CHAR_OR: begin
                  if (want_op) begin
                     err_in = ERR_MISPLACED;
                  end else begin
                     terms_in.term_or  = terms_ff.term_or | terms_ff.term_and;
                     terms_in.term_and = 1'b1;
                     prev_in           = CLS_BINOP;
                  end
               end
               CHAR_OPEN: begin
                  if (!want_op) begin
                     err_in = ERR_MISPLACED;
                  end else if (nest_ff == LEVEL_W'(NEST_DEPTH)) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     stack_ctrl.push = accept;
                     nest_in         = nest_ff + LEVEL_W'(1);
                     terms_in        = TERMS_RESET;
                     prev_in         = CLS_OPEN;
                  end
               end
               CHAR_CLOSE: begin
                  if (want_op) begin
                     err_in = ERR_MISPLACED;
                  end else if (nest_ff == '0) begin
                     err_in = ERR_UNBALANCED;
                  end else begin
                     stack_ctrl.pop = accept;
                     nest_in        = nest_ff - LEVEL_W'(1);
                     terms_in       = take_operand(stack_top, inner);
                     prev_in        = CLS_OPERAND;
                  end
               end
               default: begin
                  err_in = ERR_ILLEGAL;
               end
            endcase
         end
      end
   end

   always_comb begin
      err_final = err_in;
      if (err_in == ERR_NONE) begin
         if (nest_in != '0) begin
            err_final = ERR_UNBALANCED;
         end else if (prev_in != CLS_OPERAND) begin
            err_final = ERR_INCOMPLETE;
         end
      end
      rsp_data_in.expression_valid = (err_final == ERR_NONE);
      rsp_data_in.expression_value = (err_final == ERR_NONE) &&
                                     (terms_in.term_or || terms_in.term_and);
      rsp_data_in.error_kind       = err_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         values_ff    <= '0;
         terms_ff     <= TERMS_RESET;
         nest_ff      <= '0;
         prev_ff      <= CLS_START;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            values_ff <= csr_write_data;
         end
         if (accept) begin
            if (req_data.last_char) begin
               terms_ff <= TERMS_RESET;
               nest_ff  <= '0;
               prev_ff  <= CLS_START;
               err_ff   <= ERR_NONE;
            end else begin
               terms_ff <= terms_in;
               nest_ff  <= nest_in;
               prev_ff  <= prev_in;
               err_ff   <= err_in;
            end
         end
         if (accept && req_data.last_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_char) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BEE_ASSERT(a_nest_bound, nest_ff <= LEVEL_W'(NEST_DEPTH), "nest level beyond stack depth")
   `BEE_ASSERT(a_last_gives_rsp, accept && req_data.last_char |=> rsp_valid,
               "no result after last character")
   `BEE_ASSERT(a_valid_matches_err,
               rsp_valid |-> (rsp_data.expression_valid == (rsp_data.error_kind == ERR_NONE)),
               "valid flag disagrees with error kind")
   `BEE_ASSERT(a_invalid_zero,
               rsp_valid && !rsp_data.expression_valid |-> !rsp_data.expression_value,
               "value set on invalid expression")
   `BEE_ASSERT_ALWAYS(a_reset_clears,
                      reset |=> !rsp_valid && nest_ff == '0 && err_ff == ERR_NONE,
                      "state not cleared by reset")

endmodule

// File: tb/boolean_expression_evaluator_checker.sv
// Checker that predicts and compares boolean expression evaluator results.
module boolean_expression_evaluator_checker
   import bee_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_type             rsp_data,
   input  logic                csr_write_en,
   input  logic [NUM_VARS-1:0] csr_write_data,
   output int                  mismatches,
   output int                  verdicts_waiting,
   output int                  verdicts_checked,
   output int                  valid_verdicts
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_W = $clog2(NEST_DEPTH);

   logic [NUM_VARS-1:0] truth_bits;
   terms_type           saved_terms [NEST_DEPTH];
   terms_type           terms;
   logic [LEVEL_W-1:0]  open_levels;
   logic [2:0]          last_cls;
   logic [2:0]          first_err;
   rsp_type             verdict_q [$];
   int                  mismatch_n = 0;
   int                  checked_n = 0;
   int                  valid_n = 0;

   function automatic void clear_expression();
      terms       = TERMS_RESET;
      open_levels = '0;
      last_cls    = CLS_START;
      first_err   = ERR_NONE;
   endfunction

   function automatic void take_value(logic v);
      logic bit_v;
      bit_v = v ^ terms.term_neg;
      if (!bit_v) terms.term_and = 1'b0;
      terms.term_neg = 1'b0;
      last_cls       = CLS_OPERAND;
   endfunction

   function automatic void fold_char(logic [7:0] raw);
      logic [7:0] c;
      logic       need_operand;
      logic       inner;
      need_operand = (last_cls != CLS_OPERAND);
      c = raw;
      if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z) c = raw - CASE_OFFSET;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         if (!need_operand) first_err = ERR_MISPLACED;
         else take_value(truth_bits[VAR_IDX_W'(c - CHAR_UPPER_A)]);
      end else if (c == CHAR_NOT) begin
         if (!need_operand) first_err = ERR_MISPLACED;
         else begin
            terms.term_neg = ~terms.term_neg;
            last_cls       = CLS_NOT;
         end
      end else if (c == CHAR_AND) begin
         if (need_operand) first_err = ERR_MISPLACED;
         else last_cls = CLS_BINOP;
      end else if (c == CHAR_OR) begin
         if (need_operand) first_err = ERR_MISPLACED;
         else begin
            if (terms.term_and) terms.term_or = 1'b1;
            terms.term_and = 1'b1;
            last_cls       = CLS_BINOP;
         end
      end else if (c == CHAR_OPEN) begin
         if (!need_operand) first_err = ERR_MISPLACED;
         else if (open_levels >= NEST_DEPTH) first_err = ERR_OVERFLOW;
         else begin
            saved_terms[open_levels[SLOT_W-1:0]] = terms;
            open_levels = open_levels + LEVEL_W'(1);
            terms       = TERMS_RESET;
            last_cls    = CLS_OPEN;
         end
      end else if (c == CHAR_CLOSE) begin
         if (need_operand) first_err = ERR_MISPLACED;
         else if (open_levels == 0) first_err = ERR_UNBALANCED;
         else begin
            inner       = terms.term_or | terms.term_and;
            open_levels = open_levels - LEVEL_W'(1);
            terms       = saved_terms[open_levels[SLOT_W-1:0]];
            take_value(inner);
         end
      end else begin
         first_err = ERR_ILLEGAL;
      end
   endfunction

   function automatic rsp_type close_expression();
      rsp_type    r;
      logic [2:0] e;
      e = first_err;
      if (e == ERR_NONE) begin
         if (open_levels != 0) e = ERR_UNBALANCED;
         else if (last_cls != CLS_OPERAND) e = ERR_INCOMPLETE;
      end
      r.expression_valid = (e == ERR_NONE);
      r.expression_value = (e == ERR_NONE) && (terms.term_or | terms.term_and);
      r.error_kind       = e;
      clear_expression();
      return r;
   endfunction

   function automatic void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_n++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type oldest;
      if (reset) begin
         truth_bits = '0;
         clear_expression();
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: result with none expected, got valid %b value %b error %0d",
                        $time, rsp_data.expression_valid, rsp_data.expression_value,
                        rsp_data.error_kind);
               mismatch_n++;
            end else begin
               oldest = verdict_q.pop_front();
               checked_n++;
               if (oldest.expression_valid) valid_n++;
               compare_field("expression_valid", oldest.expression_valid,
                             rsp_data.expression_valid);
               compare_field("expression_value", oldest.expression_value,
                             rsp_data.expression_value);
               compare_field("error_kind", oldest.error_kind, rsp_data.error_kind);
            end
         end
         if (csr_write_en) truth_bits = csr_write_data;
         if (req_valid && req_ready) begin
            if (first_err == ERR_NONE) fold_char(req_data.char_code);
            if (req_data.last_char) verdict_q.push_back(close_expression());
         end
      end
      mismatches       <= mismatch_n;
      verdicts_waiting <= verdict_q.size();
      verdicts_checked <= checked_n;
      valid_verdicts   <= valid_n;
   end

endmodule

// File: tb/boolean_expression_evaluator_tb.sv
// Testbench top: drives expressions and variable settings into the evaluator.
module boolean_expression_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bee_pkg::*;

   localparam int         LIMIT_CYCLES  = 500_000;
   localparam int         HOLD_CYCLES   = 150;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         PHASE_CHARS   = 270;
   localparam int         NUM_PHASES    = 6;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_en = 1'b0;
   logic [NUM_VARS-1:0] csr_write_data = '0;

   int   mismatches;
   int   verdicts_waiting;
   int   verdicts_checked;
   int   valid_verdicts;

   logic rsp_stalls = 1'b0;
   logic send_gaps = 1'b0;
   int   hold_reqs = 0;
   int   hold_seen = 0;
   int   stall_left = 0;
   int   cycles = 0;
   int   chars_sent = 0;
   int   exprs_sent = 0;
   int   settings_used = 0;

   logic [7:0] expr_q [$];

   boolean_expression_evaluator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   boolean_expression_evaluator_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .verdicts_waiting (verdicts_waiting),
      .verdicts_checked (verdicts_checked),
      .valid_verdicts   (valid_verdicts)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen  = hold_reqs;
         stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rsp_stalls && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic is_last);
      int gap;
      gap = (send_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, last_char: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_expr();
      for (int i = 0; i < expr_q.size(); i++) send_char(expr_q[i], i == expr_q.size() - 1);
      exprs_sent++;
   endtask

   task automatic send_text(input string s);
      expr_q.delete();
      for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
      send_expr();
   endtask

   // Sender pauses until every predicted result is out, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vars(input logic [NUM_VARS-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] idx;
      idx = 8'($urandom_range(0, NUM_VARS - 1));
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + idx;
   endfunction

   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 9))
         0: return CHAR_NOT;
         1: return CHAR_AND;
         2: return CHAR_OR;
         3: return CHAR_OPEN;
         4: return CHAR_CLOSE;
         5: return CHAR_SPACE;
         6: return CHAR_UPPER_A - 8'd1;
         7: return CHAR_UPPER_Z + 8'd1;
         8: return CHAR_LOWER_A - 8'd1;
         default: return CHAR_LOWER_Z + 8'd1;
      endcase
   endfunction

   // Well-formed expression by random walk over the grammar.
   task automatic build_expr(input int max_depth);
      int   depth;
      int   operands;
      int   target;
      logic need_operand;
      logic done;
      expr_q.delete();
      depth        = 0;
      operands     = 0;
      target       = $urandom_range(1, 6);
      need_operand = 1'b1;
      done         = 1'b0;
      while (!done) begin
         if (need_operand) begin
            if ($urandom_range(0, 4) == 0) expr_q.push_back(CHAR_NOT);
            if (depth < max_depth && $urandom_range(0, 3) == 0) begin
               expr_q.push_back(CHAR_OPEN);
               depth++;
            end else begin
               expr_q.push_back(random_letter());
               operands++;
               need_operand = 1'b0;
            end
         end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
            expr_q.push_back(CHAR_CLOSE);
            depth--;
         end else if (operands >= target) begin
            done = 1'b1;
         end else begin
            expr_q.push_back($urandom_range(0, 1) ? CHAR_AND : CHAR_OR);
            need_operand = 1'b1;
         end
      end
      repeat (depth) expr_q.push_back(CHAR_CLOSE);
   endtask

   // Straight nesting around one letter, up to two past the stack depth.
   task automatic build_chain(input int levels);
      expr_q.delete();
      repeat (levels) expr_q.push_back(CHAR_OPEN);
      if ($urandom_range(0, 1)) expr_q.push_back(CHAR_NOT);
      expr_q.push_back(random_letter());
      repeat (levels) expr_q.push_back(CHAR_CLOSE);
   endtask

   task automatic mangle_expr();
      int pos;
      pos = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 3))
         0: expr_q[pos] = 8'($urandom_range(0, 255));
         1: if (expr_q.size() > 1) expr_q.delete(pos);
         2: expr_q.insert(pos, odd_char());
         default: while (expr_q.size() > pos + 1) void'(expr_q.pop_back());
      endcase
   endtask

   task automatic random_phase(input int chars);
      int stop_at;
      int r;
      stop_at = chars_sent + chars;
      while (chars_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            build_chain($urandom_range(NEST_DEPTH - 2, NEST_DEPTH + 2));
         end else if (r < 9) begin
            expr_q.delete();
            repeat ($urandom_range(1, 5)) expr_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_expr(r < 15 ? NEST_DEPTH : 3);
            if ($urandom_range(0, 3) == 0) mangle_expr();
         end
         send_expr();
      end
   endtask

   initial begin
      logic [31:0] pattern;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_vars(26'h2AAAAAA);

      send_text("z");
      send_text("!A*b");
      send_text("a+B");
      send_text("(A)");
      send_text("A)");
      send_text("()");
      send_text("A!b");
      send_text("A*");
      send_text("(");
      send_text(" ");
      expr_q.delete();
      expr_q.push_back(8'hFF);
      send_expr();

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         pattern = $urandom;
         case (p)
            0: write_vars('0);
            1: write_vars('1);
            2: write_vars(26'h1555555);
            default: write_vars(pattern[NUM_VARS-1:0]);
         endcase
         send_gaps = (p != 1);
         rsp_stalls <= (p != 1);
         if (p == 3) begin
            // long result hold-off while characters keep coming back to back
            send_gaps = 1'b0;
            hold_reqs <= hold_reqs + 1;
            repeat (12) send_text("a*B+!c");
            send_gaps = 1'b1;
         end
         random_phase(PHASE_CHARS);
      end
      drain();

      $display("Sent %0d characters in %0d expressions over %0d variable settings.",
               chars_sent, exprs_sent, settings_used);
      $display("Compared %0d results, %0d of them well-formed expressions.",
               verdicts_checked, valid_verdicts);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/bee_pkg.sv
src/bee_stack_cell.sv
src/bee_stack.sv
src/boolean_expression_evaluator.sv
tb/boolean_expression_evaluator_checker.sv
tb/boolean_expression_evaluator_tb.sv
